@@ design/tsdht_pkg.sv @@
// ----------------------------------------------------------------------------
// tsdht_pkg
// Shared types and constants of the two-slot detection hold tracker: the
// detection record, the per-slot result record, slot status codes and the
// stream and configuration port geometry.
// ----------------------------------------------------------------------------
package tsdht_pkg;

	// Number of tracked slots, left to right
	localparam int SLOT_COUNT = 2;

	// Stream payload widths, padded to whole bytes, and the result record width
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 136;
	localparam int RES_W       = 133;

	// Configuration register indexes
	localparam logic [0:0] CFG_HOLD_RELOAD = 1'b0;
	localparam logic [0:0] CFG_EMPTY_CLASS = 1'b1;

	// Configuration reset values
	localparam logic [7:0] HOLD_RELOAD_RST = 8'd5;
	localparam logic [7:0] EMPTY_CLASS_RST = 8'd0;

	// Input item kinds carried in tuser
	localparam logic CMD_DETECTION = 1'b0;
	localparam logic CMD_FRAME_END = 1'b1;

	// Slot status codes
	typedef enum logic [1:0] {
		ST_UNDETECTED = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_EMPTY  = 2'd2
	} status_t;

	// One detection, Q12.4 geometry and Q0.16 score
	typedef struct packed {
		logic [7:0]  class_code;
		logic [15:0] score;
		logic [15:0] h;
		logic [15:0] w;
		logic [15:0] y;
		logic [15:0] x;
	} det_t;

	// One slot result; the last field sits in the lowest bits
	typedef struct packed {
		logic signed [48:0] stamp;
		logic [15:0]        h;
		logic [15:0]        w;
		logic signed [16:0] top;
		logic signed [16:0] left;
		logic [15:0]        score;
		status_t            status;
	} res_t;

endpackage

@@ design/two_slot_detection_hold_tracker.sv @@
// ----------------------------------------------------------------------------
// two_slot_detection_hold_tracker
// Gathers the detections of a frame, keeps the two with the smallest centre x
// and updates two held slots at every frame end.
// ----------------------------------------------------------------------------
// A detection item is taken every cycle unless a waiting frame end holds the
// input register, and never produces a result. A frame-end item produces two
// results, left slot then right slot, the second marked with tlast; they leave
// through a two-entry result buffer on one output port, so a frame end waits
// until the last result of the previous pair is being taken. An accepted frame
// end passes through the input register, then the result buffer, before its
// first result. Configuration takes effect on the next item.
// ----------------------------------------------------------------------------
module two_slot_detection_hold_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// center_x, center_y, box_width, box_height, score, class_code, time_ms
	input  logic [tsdht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// cmd
	input  logic [0:0]                           s_axis_tuser,
	// result stream
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// slot_status, slot_score, box_left, box_top, out_width, out_height,
	// empty_since, zero padding
	output logic [tsdht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// slot_index
	output logic [0:0]                           m_axis_tuser,
	// last_of_frame
	output logic                                 m_axis_tlast,
	// configuration
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [7:0]                           cfg_data
);

	localparam int NS = tsdht_pkg::SLOT_COUNT;

	logic [7:0]        hold_reload_q;
	logic [7:0]        empty_class_q;

	logic              valid_s1;
	logic              cmd_s1;
	tsdht_pkg::det_t   det_s1;
	logic [47:0]       time_s1;

	tsdht_pkg::det_t   cand_q [NS];
	logic [1:0]        cand_cnt_q;

	tsdht_pkg::res_t   res     [NS];
	tsdht_pkg::res_t   out_q   [NS];
	logic [1:0]        out_cnt_q;
	logic              out_sel;

	logic              s_fire;
	logic              m_fire;
	logic              room;
	logic              consume;
	logic              frame_end;
	logic              take_det;

	// Handshakes
	assign m_fire    = m_axis_tvalid && m_axis_tready;
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign room      = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_axis_tready);
	assign consume   = valid_s1 && ((cmd_s1 == tsdht_pkg::CMD_DETECTION) || room);
	assign frame_end = valid_s1 && (cmd_s1 == tsdht_pkg::CMD_FRAME_END) && room;
	assign take_det  = valid_s1 && (cmd_s1 == tsdht_pkg::CMD_DETECTION);
	assign s_axis_tready = !valid_s1 || consume;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_reload_q <= tsdht_pkg::HOLD_RELOAD_RST;
			empty_class_q <= tsdht_pkg::EMPTY_CLASS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsdht_pkg::CFG_HOLD_RELOAD: hold_reload_q <= cfg_data;
				tsdht_pkg::CFG_EMPTY_CLASS: empty_class_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1             <= s_axis_tuser[0];
			det_s1.x           <= s_axis_tdata[15:0];
			det_s1.y           <= s_axis_tdata[31:16];
			det_s1.w           <= s_axis_tdata[47:32];
			det_s1.h           <= s_axis_tdata[63:48];
			det_s1.score       <= s_axis_tdata[79:64];
			det_s1.class_code  <= s_axis_tdata[87:80];
			time_s1            <= s_axis_tdata[135:88];
		end
	end

	// Keep the two smallest centre x; ties go to the earlier detection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_cnt_q <= 2'd0;
			cand_q[0]  <= '0;
			cand_q[1]  <= '0;
		end else if (frame_end) begin
			cand_cnt_q <= 2'd0;
		end else if (take_det) begin
			if (cand_cnt_q == 2'd0) begin
				cand_q[0]  <= det_s1;
				cand_cnt_q <= 2'd1;
			end else begin
				if (det_s1.x < cand_q[0].x) begin
					cand_q[1] <= cand_q[0];
					cand_q[0] <= det_s1;
				end else if ((cand_cnt_q == 2'd1) || (det_s1.x < cand_q[1].x)) begin
					cand_q[1] <= det_s1;
				end
				cand_cnt_q <= 2'd2;
			end
		end
	end

	// Tracked slots, left to right
	for (genvar g = 0; g < NS; g++) begin : g_slot
		tsdht_slot u_slot (
			.clk         (clk),
			.arst_n      (arst_n),
			.update      (frame_end),
			.has_det     (cand_cnt_q > 2'(g)),
			.det         (cand_q[g]),
			.hold_reload (hold_reload_q),
			.empty_class (empty_class_q),
			.now         (time_s1),
			.nxt         (res[g])
		);
	end

	// Result buffer: count of undelivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (frame_end) begin
			out_cnt_q <= 2'd2;
		end else if (m_fire) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	// Result buffer: payload, loaded as a pair
	always_ff @(posedge clk) begin
		if (frame_end) begin
			out_q[0] <= res[0];
			out_q[1] <= res[1];
		end
	end

	// Present the left slot first, then the right slot
	assign out_sel       = (out_cnt_q == 2'd1);
	assign m_axis_tvalid = (out_cnt_q != 2'd0);
	assign m_axis_tdata  = {{(tsdht_pkg::OUT_TDATA_W - tsdht_pkg::RES_W){1'b0}},
		out_q[out_sel]};
	assign m_axis_tuser  = out_sel;
	assign m_axis_tlast  = out_sel;

endmodule

@@ design/tsdht_slot.sv @@
// ----------------------------------------------------------------------------
// tsdht_slot
// State of one tracked slot. On a frame end the slot either takes its
// detection or counts its hold down, going undetected once the hold is spent.
// The next state is also shown at nxt so the result can be captured at once.
// ----------------------------------------------------------------------------
module tsdht_slot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                update,      // frame end processed this cycle
	input  logic                has_det,     // a detection belongs to this slot
	input  tsdht_pkg::det_t     det,
	input  logic [7:0]          hold_reload,
	input  logic [7:0]          empty_class,
	input  logic [47:0]         now,
	output tsdht_pkg::res_t     nxt
);

	tsdht_pkg::res_t cur_q;
	logic [7:0]      hold_q;
	logic [7:0]      hold_n;

	// Work out the slot state after this frame
	always_comb begin
		nxt    = cur_q;
		hold_n = hold_q;
		if (has_det) begin
			hold_n    = hold_reload;
			nxt.score = det.score;
			nxt.left  = $signed({1'b0, det.x} - {2'b00, det.w[15:1]});
			nxt.top   = $signed({1'b0, det.y} - {2'b00, det.h[15:1]});
			nxt.w     = det.w;
			nxt.h     = det.h;
			if (det.class_code == empty_class) begin
				// stamp only on entry to empty
				if (cur_q.status != tsdht_pkg::ST_EMPTY) begin
					nxt.stamp  = $signed({1'b0, now});
					nxt.status = tsdht_pkg::ST_EMPTY;
				end
			end else begin
				nxt.status = tsdht_pkg::ST_NOT_EMPTY;
				nxt.stamp  = '1;
			end
		end else if (hold_q != 8'd0) begin
			hold_n = hold_q - 8'd1;
		end else begin
			// hold spent: drop to undetected, keep the box
			nxt.status = tsdht_pkg::ST_UNDETECTED;
			nxt.stamp  = '1;
			nxt.score  = 16'd0;
		end
	end

	// Commit on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			hold_q <= 8'd0;
		end else if (update) begin
			cur_q  <= nxt;
			hold_q <= hold_n;
		end
	end

endmodule

@@ design/tsdht_checker.sv @@
// ----------------------------------------------------------------------------
// tsdht_checker
// Port-level checks of the tracker's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tsdht_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [tsdht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                        m_axis_tuser,
	input logic                              m_axis_tlast
);

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The right slot follows the left slot straight away
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && (m_axis_tuser == 1'b1))
		else $error("right slot result missing after left slot");

	// Frame end mark sits on the right slot only
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser[0]))
		else $error("tlast does not match slot index");

	// An undetected slot has no score and no stamp
	a_undetected: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == 2'd0)
		|-> (m_axis_tdata[17:2] == 16'd0) && (m_axis_tdata[132:84] == {49{1'b1}}))
		else $error("undetected slot with score or stamp");

	// A not-empty slot has no stamp
	a_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == 2'd2)
		|-> (m_axis_tdata[132:84] == {49{1'b1}}))
		else $error("not-empty slot carries an empty stamp");

endmodule

bind two_slot_detection_hold_tracker tsdht_checker u_tsdht_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-slot detection hold tracker. Frames of
// detections followed by a frame-end item are streamed in, a behavioural
// tracker predicts the two slot results of every frame end, and each result
// leaving the block is compared field by field. Phases change the hold and
// empty-class registers and the idling of both stream sides.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One input item: detection fields, frame-end time, optional drain hold
	typedef struct {
		logic               cmd;
		tsdht_pkg::det_t    det;
		logic [47:0]        t_ms;
		bit                 wait_drain;
	} stim_item_t;

	// One awaited slot result
	typedef struct {
		logic               idx;
		tsdht_pkg::status_t status;
		logic [15:0]        score;
		logic signed [16:0] left;
		logic signed [16:0] top;
		logic [15:0]        w;
		logic [15:0]        h;
		logic [48:0]        stamp;
		logic               last;
	} slot_due_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [tsdht_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]                        s_axis_tuser = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [tsdht_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]                        m_axis_tuser;
	logic                              m_axis_tlast;
	logic                              cfg_we = 1'b0;
	logic [0:0]                        cfg_index = '0;
	logic [7:0]                        cfg_data = '0;

	two_slot_detection_hold_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	stim_item_t feed[$];
	stim_item_t on_bus;
	slot_due_t  slot_results_due[$];
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	// Tracker copy: registers, kept detections and held slots
	logic [7:0]         hold_cfg = tsdht_pkg::HOLD_RELOAD_RST;
	logic [7:0]         empty_cfg = tsdht_pkg::EMPTY_CLASS_RST;
	int                 cand_cnt = 0;
	tsdht_pkg::det_t    cands [tsdht_pkg::SLOT_COUNT];
	tsdht_pkg::status_t trk_status [tsdht_pkg::SLOT_COUNT];
	logic [7:0]         trk_hold [tsdht_pkg::SLOT_COUNT];
	logic [15:0]        trk_score [tsdht_pkg::SLOT_COUNT];
	logic signed [16:0] trk_left [tsdht_pkg::SLOT_COUNT];
	logic signed [16:0] trk_top [tsdht_pkg::SLOT_COUNT];
	logic [15:0]        trk_w [tsdht_pkg::SLOT_COUNT];
	logic [15:0]        trk_h [tsdht_pkg::SLOT_COUNT];
	logic [48:0]        trk_stamp [tsdht_pkg::SLOT_COUNT];

	initial begin
		for (int s = 0; s < tsdht_pkg::SLOT_COUNT; s++) begin
			cands[s] = '0;
			trk_status[s] = tsdht_pkg::ST_UNDETECTED;
			trk_hold[s] = '0;
			trk_score[s] = '0;
			trk_left[s] = '0;
			trk_top[s] = '0;
			trk_w[s] = '0;
			trk_h[s] = '0;
			trk_stamp[s] = '0;
		end
	end

	// Keep the two detections with the smallest centre x, earlier wins a tie
	task automatic gather_detection(input tsdht_pkg::det_t d);
		if (cand_cnt == 0) begin
			cands[0] = d;
			cand_cnt = 1;
		end else if (cand_cnt == 1) begin
			if (d.x < cands[0].x) begin
				cands[1] = cands[0];
				cands[0] = d;
			end else begin
				cands[1] = d;
			end
			cand_cnt = 2;
		end else if (d.x < cands[0].x) begin
			cands[1] = cands[0];
			cands[0] = d;
		end else if (d.x < cands[1].x) begin
			cands[1] = d;
		end
	endtask

	// Update both slots at frame end and queue the two results
	task automatic close_frame(input logic [47:0] now);
		slot_due_t r;
		for (int s = 0; s < tsdht_pkg::SLOT_COUNT; s++) begin
			if (s < cand_cnt) begin
				trk_hold[s] = hold_cfg;
				trk_score[s] = cands[s].score;
				trk_left[s] = {1'b0, cands[s].x} - {2'b0, cands[s].w[15:1]};
				trk_top[s] = {1'b0, cands[s].y} - {2'b0, cands[s].h[15:1]};
				trk_w[s] = cands[s].w;
				trk_h[s] = cands[s].h;
				if (cands[s].class_code == empty_cfg) begin
					// stamp only on entry to empty
					if (trk_status[s] != tsdht_pkg::ST_EMPTY) begin
						trk_stamp[s] = {1'b0, now};
						trk_status[s] = tsdht_pkg::ST_EMPTY;
					end
				end else begin
					trk_status[s] = tsdht_pkg::ST_NOT_EMPTY;
					trk_stamp[s] = '1;
				end
			end else if (trk_hold[s] != 0) begin
				trk_hold[s] = trk_hold[s] - 8'd1;
			end else begin
				trk_status[s] = tsdht_pkg::ST_UNDETECTED;
				trk_stamp[s] = '1;
				trk_score[s] = '0;
			end
			r.idx = s[0];
			r.status = trk_status[s];
			r.score = trk_score[s];
			r.left = trk_left[s];
			r.top = trk_top[s];
			r.w = trk_w[s];
			r.h = trk_h[s];
			r.stamp = trk_stamp[s];
			r.last = (s == tsdht_pkg::SLOT_COUNT - 1);
			slot_results_due.push_back(r);
		end
		cand_cnt = 0;
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Input driver: predict accepted items, present the next pending one
	always @(posedge clk or negedge arst_n) begin : item_driver
		bit go;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (on_bus.cmd == tsdht_pkg::CMD_FRAME_END)
					close_frame(on_bus.t_ms);
				else
					gather_detection(on_bus.det);
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				go = feed.size() > 0 && $urandom_range(99) >= send_idle_pct;
				if (go && feed[0].wait_drain && slot_results_due.size() > 0)
					go = 1'b0;
				if (go) begin
					on_bus = feed.pop_front();
					s_axis_tdata <= {on_bus.t_ms, on_bus.det};
					s_axis_tuser <= on_bus.cmd;
				end
				s_axis_tvalid <= go;
			end
		end
	end

	// Result monitor: compare each accepted result with the oldest awaited one
	always @(posedge clk or negedge arst_n) begin : result_monitor
		slot_due_t       want;
		tsdht_pkg::res_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[tsdht_pkg::RES_W-1:0];
				if (slot_results_due.size() == 0) begin
					flag_mismatch("result with nothing awaited", got.status, 0);
				end else begin
					want = slot_results_due.pop_front();
					if (m_axis_tuser[0] !== want.idx)
						flag_mismatch("slot_index", m_axis_tuser[0], want.idx);
					if (got.status !== want.status)
						flag_mismatch("slot_status", got.status, want.status);
					if (got.score !== want.score)
						flag_mismatch("slot_score", got.score, want.score);
					if (got.left !== want.left)
						flag_mismatch("box_left", got.left, want.left);
					if (got.top !== want.top)
						flag_mismatch("box_top", got.top, want.top);
					if (got.w !== want.w)
						flag_mismatch("out_width", got.w, want.w);
					if (got.h !== want.h)
						flag_mismatch("out_height", got.h, want.h);
					if (got.stamp !== want.stamp)
						flag_mismatch("empty_since", got.stamp, want.stamp);
					if (m_axis_tlast !== want.last)
						flag_mismatch("last_of_frame", m_axis_tlast, want.last);
				end
			end
			m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	task automatic add_det(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w, input logic [15:0] h, input logic [15:0] score,
			input logic [7:0] cls);
		stim_item_t it;
		it.cmd = tsdht_pkg::CMD_DETECTION;
		it.det.x = x;
		it.det.y = y;
		it.det.w = w;
		it.det.h = h;
		it.det.score = score;
		it.det.class_code = cls;
		it.t_ms = 48'({$urandom, $urandom});
		it.wait_drain = 1'b0;
		feed.push_back(it);
	endtask

	task automatic add_end(input logic [47:0] t_ms, input bit wait_drain);
		stim_item_t  it;
		logic [95:0] junk;
		junk = {$urandom, $urandom, $urandom};
		it.cmd = tsdht_pkg::CMD_FRAME_END;
		it.det = junk[87:0];
		it.t_ms = t_ms;
		it.wait_drain = wait_drain;
		feed.push_back(it);
	endtask

	// Random frames: a few detections with frequent x ties, then a frame end
	task automatic add_random_frames(input int n_items);
		int          n_det;
		int          pick;
		logic [15:0] x;
		logic [7:0]  cls;
		while (n_items > 0) begin
			pick = $urandom_range(99);
			n_det = pick < 15 ? 0 : pick < 40 ? 1 : pick < 70 ? 2 : $urandom_range(6, 3);
			for (int k = 0; k < n_det; k++) begin
				case ($urandom_range(3))
					0: x = 16'd0;
					1: x = 16'($urandom_range(3)) << 14;
					default: x = 16'($urandom);
				endcase
				pick = $urandom_range(99);
				cls = pick < 40 ? empty_cfg : pick < 50 ? 8'hFF : 8'($urandom);
				add_det(x, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), cls);
			end
			add_end(48'({$urandom, $urandom}), $urandom_range(99) < 2);
			n_items -= n_det + 1;
		end
	endtask

	// Hold until the block is idle and every awaited result has arrived
	task automatic wait_idle();
		while (feed.size() > 0 || s_axis_tvalid || slot_results_due.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == tsdht_pkg::CFG_HOLD_RELOAD)
			hold_cfg = value;
		else
			empty_cfg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Phases of stimulus, configuration and idling
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames under the reset settings
		add_end(48'd0, 1'b0);
		add_det(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd0);
		add_det(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 8'hFF);
		add_end(48'hFFFF_FFFF_FFFF, 1'b0);
		add_det(16'd10, 16'd20, 16'd7, 16'd9, 16'h8000, 8'd0);
		add_end(48'd5, 1'b0);
		add_det(16'd10, 16'd20, 16'd7, 16'd9, 16'h0001, 8'd0);
		add_end(48'd6, 1'b1);
		add_det(16'd100, 16'd1, 16'd2, 16'd3, 16'd4, 8'd3);
		add_det(16'd100, 16'd5, 16'd6, 16'd7, 16'd8, 8'd0);
		add_det(16'd50, 16'd9, 16'd10, 16'd11, 16'd12, 8'd0);
		add_det(16'd200, 16'd13, 16'd14, 16'd15, 16'd16, 8'd1);
		add_end(48'h0000_8000_0001, 1'b0);
		for (int k = 0; k < 7; k++)
			add_end(48'd1000 + k, 1'b0);
		wait_idle();

		write_reg(tsdht_pkg::CFG_HOLD_RELOAD, 8'd0);
		write_reg(tsdht_pkg::CFG_EMPTY_CLASS, 8'hFF);
		add_random_frames(300);
		wait_idle();

		write_reg(tsdht_pkg::CFG_HOLD_RELOAD, 8'd255);
		write_reg(tsdht_pkg::CFG_EMPTY_CLASS, 8'd7);
		send_idle_pct = 72;
		add_random_frames(300);
		wait_idle();

		write_reg(tsdht_pkg::CFG_HOLD_RELOAD, 8'd2);
		write_reg(tsdht_pkg::CFG_EMPTY_CLASS, 8'd0);
		send_idle_pct = 0;
		recv_stall_pct = 72;
		add_random_frames(300);
		wait_idle();

		write_reg(tsdht_pkg::CFG_HOLD_RELOAD, 8'd1);
		write_reg(tsdht_pkg::CFG_EMPTY_CLASS, 8'($urandom));
		send_idle_pct = 28;
		recv_stall_pct = 28;
		add_random_frames(300);
		wait_idle();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
